// ----- rtl/sfd_pkg.sv -----
// Shared constants and types of the serial frame deframer.
`default_nettype none
package sfd_pkg;

  localparam logic [7:0] SYNC_BYTE     = 8'hAB;
  localparam logic [7:0] HEADER_SECOND = 8'h01;
  localparam logic [7:0] CHECK_START   = 8'h00;

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_COMMAND = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLE = 8'd1;

  typedef struct packed {
    logic       emit;
    logic [7:0] data_byte;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic       end_of_frame;
    logic       check_ok;
  } sfd_result_t;

endpackage
`default_nettype wire

// ----- rtl/serial_frame_deframer.sv -----
// Top level of the serial frame deframer: input register, parser and result register.
// A payload or check byte passes through the input register, the parser and the result register to the output.
// Throughput: one byte per cycle unless output back-pressure (m_axis_tready low) stalls the pipeline.
// A held result does not stall input while the input register is free.
// Reset: synchronous active-high rst returns the parser to sync hunting and clears
// both registers' valid flags and the configuration registers.
`default_nettype none
module serial_frame_deframer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output      logic [23:0]                     m_axis_tdata,  // data_byte, frame_command, frame_length
  output      logic                            m_axis_tlast,  // end_of_frame
  output      logic                            m_axis_tuser,  // check_ok
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                      cfg_data
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 advance;
  logic [7:0]           match_command;
  logic                 filter_enable;
  sfd_pkg::sfd_result_t result;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_command <= 8'd0;
      filter_enable <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == sfd_pkg::REG_MATCH_COMMAND) begin
        match_command <= cfg_data;
      end else if (cfg_index == sfd_pkg::REG_FILTER_ENABLE) begin
        filter_enable <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  sfd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (in_valid && advance),
    .rx_byte       (in_byte),
    .match_command (match_command),
    .filter_enable (filter_enable),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid && result.emit;
    end
    if (advance && in_valid && result.emit) begin
      m_axis_tdata <= {result.frame_length, result.frame_command, result.data_byte};
      m_axis_tlast <= result.end_of_frame;
      m_axis_tuser <= result.check_ok;
    end
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid && !in_valid)
    else $error("valid flags not cleared by reset");
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("pending input byte lost during output stall");
  a_ok_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser)
    else $error("checksum verdict on a payload result");
  a_out_from_input: assert property (@(posedge clk) disable iff (rst)
    !$past(in_valid) && !$past(m_axis_tvalid) |-> !m_axis_tvalid)
    else $error("result without an input byte");
`endif

endmodule
`default_nettype wire

// ----- rtl/sfd_parser.sv -----
// Frame parser state and the per-byte result logic of the serial frame deframer.
`default_nettype none
module sfd_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [7:0]         rx_byte,
  input  wire logic [7:0]         match_command,
  input  wire logic               filter_enable,
  output sfd_pkg::sfd_result_t    result
);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC  = 3'd1,
    PH_CMD   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] held_command, held_command_next;
  logic [7:0] held_length, held_length_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_check, running_check_next;
  logic       frame_kept, frame_kept_next;
  logic [7:0] check_sum;
  logic [7:0] left_dec;

  assign check_sum = running_check + rx_byte;
  assign left_dec  = bytes_left - 8'd1;

  always_comb begin
    phase_next         = phase;
    held_command_next  = held_command;
    held_length_next   = held_length;
    bytes_left_next    = bytes_left;
    running_check_next = running_check;
    frame_kept_next    = frame_kept;
    result.emit          = 1'b0;
    result.data_byte     = rx_byte;
    result.frame_command = held_command;
    result.frame_length  = held_length;
    result.end_of_frame  = 1'b0;
    result.check_ok      = 1'b0;
    unique case (phase)
      PH_SYNC: begin
        if (rx_byte == sfd_pkg::HEADER_SECOND) begin
          running_check_next = sfd_pkg::CHECK_START + rx_byte;
          phase_next         = PH_CMD;
        end else if (rx_byte != sfd_pkg::SYNC_BYTE) begin
          phase_next = PH_HUNT;
        end
      end
      PH_CMD: begin
        held_command_next  = rx_byte;
        running_check_next = check_sum;
        frame_kept_next    = !filter_enable || (rx_byte == match_command);
        phase_next         = PH_LEN;
      end
      PH_LEN: begin
        held_length_next   = rx_byte;
        bytes_left_next    = rx_byte;
        running_check_next = check_sum;
        phase_next         = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        result.emit        = frame_kept;
        running_check_next = check_sum;
        bytes_left_next    = left_dec;
        if (left_dec == 8'd0) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        result.emit         = frame_kept;
        result.end_of_frame = 1'b1;
        result.check_ok     = (check_sum == sfd_pkg::CHECK_START);
        phase_next          = PH_HUNT;
      end
      default: begin
        phase_next = (rx_byte == sfd_pkg::SYNC_BYTE) ? PH_SYNC : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      held_command  <= 8'd0;
      held_length   <= 8'd0;
      bytes_left    <= 8'd0;
      running_check <= sfd_pkg::CHECK_START;
      frame_kept    <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      held_command  <= held_command_next;
      held_length   <= held_length_next;
      bytes_left    <= bytes_left_next;
      running_check <= running_check_next;
      frame_kept    <= frame_kept_next;
    end
  end

endmodule
`default_nettype wire
